// ===== hdl/ftl_pkg.sv =====
package ftl_pkg;

   localparam int DEFAULT_SLOTS = 64;

   localparam int ADDR_W      = 32;
   localparam int PORT_W      = 16;
   localparam int ID_W        = 16;
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int LIMIT_W     = 7;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [ID_W-1:0]    ID_FIRST    = 16'd1;
   localparam logic [ID_W-1:0]    ID_LAST     = 16'hFFFF;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOOKUP    = 2'd0,
      ACT_MARK_SENT = 2'd1,
      ACT_CLEAR     = 2'd2,
      ACT_UNUSED    = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_FOUND   = 2'd0,
      ST_CREATED = 2'd1,
      ST_FULL    = 2'd2,
      ST_DONE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ACT,
      S_MARK_RD,
      S_MARK_WR,
      S_OUT
   } state_type;

endpackage

// ===== hdl/flow_table_lookup_or_insert.sv =====
// connection table keyed by destination address and port, held in one
// synchronous memory (one read and one write port, registered read data)
// request channel: req_tvalid/req_tready, action in req_tuser, key and
// arguments in req_tdata; one response per request on rsp_tvalid/rsp_tready
// with the status code in rsp_tuser
// lookup or create reads every slot once to find a match and the lowest free
// slot, then writes back at most one entry
// mark sent is a read-modify-write of one slot
// clear table sweeps the memory one slot a cycle
// one request is worked on at a time; req_tready is high only when idle,
// which it is again in the cycle after the response is loaded
// the response sits in an output register, so a new request is taken while
// it waits; a finished request then holds until that register is taken
// reset runs the same sweep over every slot, req_tready low meanwhile;
// the limit register resets to 64 and may be written whenever idle
module flow_table_lookup_or_insert #(
   parameter int TABLE_SLOTS = ftl_pkg::DEFAULT_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   // config: connection_limit
   input  logic                            csr_wr_en,
   input  logic [ftl_pkg::LIMIT_W-1:0]     csr_wr_data,
   // request
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action
   input  logic [ftl_pkg::ACT_W-1:0]       req_tuser,
   // dest_addr, dest_port, rebind_req, target_slot
   input  logic [ftl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status
   output logic [ftl_pkg::STAT_W-1:0]      rsp_tuser,
   // slot_index, connection_id, rebind_flag, entry_count
   output logic [ftl_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ftl_pkg::*;

   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
   localparam int CMP_W   = ((SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W) + 1;
   localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int PORT_LO = ADDR_W;
   localparam int ID_LO   = ADDR_W + PORT_W;
   localparam int RB_BIT  = ID_LO + ID_W;
   localparam int VLD_BIT = RB_BIT + 1;
   localparam int WORD_W  = VLD_BIT + 1;

   // table memory
   logic [WORD_W-1:0] mem [TABLE_SLOTS];
   logic [WORD_W-1:0] rd_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   logic [WORD_W-1:0] mem_wd;
   logic [SLOT_W-1:0] mem_ra;

   state_type state_ff, state_in;

   // control registers
   logic                pend_ff, pend_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                hit_ff, hit_in;
   logic                free_ff, free_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ID_W-1:0]     nid_ff, nid_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // payload registers
   action_type              act_ff, act_in;
   logic [ADDR_W-1:0]       key_addr_ff, key_addr_in;
   logic [PORT_W-1:0]       key_port_ff, key_port_in;
   logic                    force_ff, force_in;
   logic [SLOT_OUT_W-1:0]   tgt_ff, tgt_in;
   logic [SLOT_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [SLOT_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [ID_W-1:0]         hit_id_ff, hit_id_in;
   logic                    hit_rb_ff, hit_rb_in;
   logic [SLOT_W-1:0]       free_idx_ff, free_idx_in;
   status_type              res_status_ff, res_status_in;
   logic [SLOT_OUT_W-1:0]   res_slot_ff, res_slot_in;
   logic [ID_W-1:0]         res_id_ff, res_id_in;
   logic                    res_rb_ff, res_rb_in;
   logic [STAT_W-1:0]       rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // derived values
   logic                    req_fire;
   logic                    out_free;
   logic                    clr_last;
   logic                    scan_issue;
   logic                    rd_match;
   logic                    rd_empty;
   logic [CMP_W-1:0]        tgt_w;
   logic                    tgt_ok;
   logic [SLOT_W-1:0]       tgt_idx;
   logic [CMP_W-1:0]        hit_slot_w;
   logic [CMP_W-1:0]        free_slot_w;
   logic [LIM_W-1:0]        lim_w;
   logic [LIM_W-1:0]        eff_lim;
   logic [LIM_W-1:0]        count_w;
   logic                    at_limit;
   logic [ID_W-1:0]         nid_next;

   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign clr_last    = (clr_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign scan_issue  = (state_ff == S_SCAN) && (scan_ff < CNT_W'(TABLE_SLOTS));
   assign rd_match    = chk_vld_ff && rd_ff[VLD_BIT]
                        && (rd_ff[ADDR_W-1:0] == key_addr_ff)
                        && (rd_ff[PORT_LO +: PORT_W] == key_port_ff);
   assign rd_empty    = chk_vld_ff && !rd_ff[VLD_BIT];
   assign tgt_w       = CMP_W'(tgt_ff);
   assign tgt_ok      = (tgt_w < CMP_W'(TABLE_SLOTS));
   assign tgt_idx     = tgt_w[SLOT_W-1:0];
   assign hit_slot_w  = CMP_W'(hit_idx_ff);
   assign free_slot_w = CMP_W'(free_idx_ff);
   assign lim_w       = LIM_W'(limit_ff);
   // zero or above capacity means full capacity
   assign eff_lim     = ((limit_ff == '0) || (lim_w > LIM_W'(TABLE_SLOTS)))
                        ? LIM_W'(TABLE_SLOTS) : lim_w;
   assign count_w     = LIM_W'(count_ff);
   assign at_limit    = (count_w >= eff_lim);
   // id counter skips zero
   assign nid_next    = (nid_ff == ID_LAST) ? ID_FIRST : nid_ff + ID_FIRST;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = pend_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (action_type'(req_tuser))
                  ACT_LOOKUP:    state_in = S_SCAN;
                  ACT_MARK_SENT: state_in = S_MARK_RD;
                  ACT_CLEAR:     state_in = S_CLEAR;
                  default:       state_in = S_OUT;
               endcase
            end
         end
         S_SCAN: begin
            if (!scan_issue && !chk_vld_ff) begin
               state_in = S_ACT;
            end
         end
         S_ACT:     state_in = S_OUT;
         S_MARK_RD: state_in = tgt_ok ? S_MARK_WR : S_OUT;
         S_MARK_WR: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs of the state machine: handshake and memory ports
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = clr_ff;
      mem_wd     = '0;
      mem_ra     = scan_ff[SLOT_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_ACT: begin
            if (hit_ff) begin
               mem_we = force_ff;
               mem_wa = hit_idx_ff;
               mem_wd = {1'b1, 1'b1, hit_id_ff, key_port_ff, key_addr_ff};
            end else begin
               mem_we = free_ff && !at_limit;
               mem_wa = free_idx_ff;
               mem_wd = {1'b1, force_ff, nid_ff, key_port_ff, key_addr_ff};
            end
         end
         S_MARK_RD: begin
            mem_ra = tgt_idx;
         end
         S_MARK_WR: begin
            mem_we = 1'b1;
            mem_wa = tgt_idx;
            mem_wd = rd_ff;
            mem_wd[RB_BIT] = 1'b0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pend_in       = pend_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      chk_vld_in    = scan_issue;
      chk_idx_in    = scan_ff[SLOT_W-1:0];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_id_in     = hit_id_ff;
      hit_rb_in     = hit_rb_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      nid_in        = nid_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      act_in        = act_ff;
      key_addr_in   = key_addr_ff;
      key_port_in   = key_port_ff;
      force_in      = force_ff;
      tgt_in        = tgt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_id_in     = res_id_ff;
      res_rb_in     = res_rb_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_last) begin
               clr_in  = '0;
               pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               act_in        = action_type'(req_tuser);
               key_addr_in   = req_tdata[ADDR_W-1:0];
               key_port_in   = req_tdata[ADDR_W +: PORT_W];
               force_in      = req_tdata[ADDR_W + PORT_W];
               tgt_in        = req_tdata[ADDR_W + PORT_W + 1 +: SLOT_OUT_W];
               scan_in       = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               res_status_in = ST_DONE;
               res_slot_in   = '0;
               res_id_in     = '0;
               res_rb_in     = 1'b0;
               case (action_type'(req_tuser))
                  ACT_MARK_SENT: begin
                     res_slot_in = req_tdata[ADDR_W + PORT_W + 1 +: SLOT_OUT_W];
                  end
                  ACT_CLEAR: begin
                     pend_in  = 1'b1;
                     clr_in   = '0;
                     count_in = '0;
                     nid_in   = ID_FIRST;
                  end
                  default: begin
                     pend_in = pend_ff;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            // keep the first match and the lowest free slot
            if (rd_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_id_in  = rd_ff[ID_LO +: ID_W];
               hit_rb_in  = rd_ff[RB_BIT];
            end
            if (rd_empty && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
         S_ACT: begin
            if (hit_ff) begin
               res_status_in = ST_FOUND;
               res_slot_in   = hit_slot_w[SLOT_OUT_W-1:0];
               res_id_in     = hit_id_ff;
               res_rb_in     = hit_rb_ff || force_ff;
            end else if (free_ff && !at_limit) begin
               res_status_in = ST_CREATED;
               res_slot_in   = free_slot_w[SLOT_OUT_W-1:0];
               res_id_in     = nid_ff;
               res_rb_in     = force_ff;
               nid_in        = nid_next;
               count_in      = count_ff + CNT_W'(1);
            end else begin
               res_status_in = ST_FULL;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = RSP_DATA_W'({count_w[COUNT_OUT_W-1:0], res_rb_ff,
                                            res_id_ff, res_slot_ff});
            end
         end
         default: begin
            act_in = act_ff;
         end
      endcase
   end

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pend_ff       <= 1'b0;
         clr_ff        <= '0;
         scan_ff       <= '0;
         chk_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         count_ff      <= '0;
         nid_ff        <= ID_FIRST;
         limit_ff      <= LIMIT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         clr_ff        <= clr_in;
         scan_ff       <= scan_in;
         chk_vld_ff    <= chk_vld_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
         nid_ff        <= nid_in;
         limit_ff      <= limit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_addr_ff   <= key_addr_in;
      key_port_ff   <= key_port_in;
      force_ff      <= force_in;
      tgt_ff        <= tgt_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_id_ff     <= hit_id_in;
      hit_rb_ff     <= hit_rb_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_id_ff     <= res_id_in;
      res_rb_ff     <= res_rb_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import ftl_pkg::*;

   localparam int SLOTS        = DEFAULT_SLOTS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 172;
   localparam int POOL_KEYS    = 16;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      action_type                act;
      logic [ADDR_W-1:0]         addr;
      logic [PORT_W-1:0]         port;
      logic                      rebind_req;
      logic [SLOT_OUT_W-1:0]     target;
   } flow_request;

   typedef struct packed {
      status_type                status;
      logic [SLOT_OUT_W-1:0]     slot;
      logic [ID_W-1:0]           conn_id;
      logic                      rebind;
      logic [COUNT_OUT_W-1:0]    count;
   } flow_response;

   typedef struct packed {
      logic                      set_limit;
      logic [LIMIT_W-1:0]        limit_val;
      flow_request               req;
      logic                      typed;
      flow_response              rsp;
   } directed_row;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]     csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ACT_W-1:0]       req_tuser = '0;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [STAT_W-1:0]      rsp_tuser;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // own copy of the connection table
   logic                   tbl_valid  [SLOTS];
   logic [ADDR_W-1:0]      tbl_addr   [SLOTS];
   logic [PORT_W-1:0]      tbl_port   [SLOTS];
   logic [ID_W-1:0]        tbl_id     [SLOTS];
   logic                   tbl_rebind [SLOTS];
   int                     tbl_count;
   logic [ID_W-1:0]        tbl_next_id;
   logic [LIMIT_W-1:0]     tbl_limit;

   flow_response           awaited_rsp [$];
   int                     mismatches = 0;
   int                     responses_seen = 0;
   int                     cycle_count = 0;
   int                     stall_left = 0;
   bit                     held_off = 1'b0;
   bit                     idle_on = 1'b1;

   flow_table_lookup_or_insert #(.TABLE_SLOTS(SLOTS)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void empty_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_addr[i]   = '0;
         tbl_port[i]   = '0;
         tbl_id[i]     = '0;
         tbl_rebind[i] = 1'b0;
      end
      tbl_count   = 0;
      tbl_next_id = ID_FIRST;
   endfunction

   // applies one request to the table copy and returns the response it earns
   function automatic flow_response table_outcome(flow_request r);
      flow_response o;
      int lim;
      int hit;
      int free_slot;
      o = '0;
      o.status = ST_DONE;
      hit = -1;
      free_slot = -1;
      lim = (tbl_limit == 0 || tbl_limit > SLOTS) ? SLOTS : int'(tbl_limit);
      case (r.act)
         ACT_LOOKUP: begin
            // walk downward so the lowest match and lowest free slot win
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (tbl_valid[i] && tbl_addr[i] == r.addr && tbl_port[i] == r.port)
                  hit = i;
               if (!tbl_valid[i])
                  free_slot = i;
            end
            if (hit >= 0) begin
               if (r.rebind_req)
                  tbl_rebind[hit] = 1'b1;
               o.status  = ST_FOUND;
               o.slot    = hit[SLOT_OUT_W-1:0];
               o.conn_id = tbl_id[hit];
               o.rebind  = tbl_rebind[hit];
            end else if (tbl_count >= lim || free_slot < 0) begin
               o.status = ST_FULL;
            end else begin
               tbl_valid[free_slot]  = 1'b1;
               tbl_addr[free_slot]   = r.addr;
               tbl_port[free_slot]   = r.port;
               tbl_id[free_slot]     = tbl_next_id;
               tbl_rebind[free_slot] = r.rebind_req;
               tbl_next_id = (tbl_next_id == ID_LAST) ? ID_FIRST : tbl_next_id + 1'b1;
               tbl_count++;
               o.status  = ST_CREATED;
               o.slot    = free_slot[SLOT_OUT_W-1:0];
               o.conn_id = tbl_id[free_slot];
               o.rebind  = r.rebind_req;
            end
         end
         ACT_MARK_SENT: begin
            tbl_rebind[r.target] = 1'b0;
            o.slot = r.target;
         end
         ACT_CLEAR: begin
            empty_table();
         end
         default: begin
         end
      endcase
      o.count = tbl_count[COUNT_OUT_W-1:0];
      return o;
   endfunction

   function automatic directed_row row(logic sl, logic [LIMIT_W-1:0] lim, action_type a,
                                       logic [ADDR_W-1:0] ad, logic [PORT_W-1:0] p,
                                       logic rb, logic [SLOT_OUT_W-1:0] t, logic ty,
                                       status_type st, logic [SLOT_OUT_W-1:0] s,
                                       logic [ID_W-1:0] id, logic rf,
                                       logic [COUNT_OUT_W-1:0] c);
      directed_row d;
      d.set_limit      = sl;
      d.limit_val      = lim;
      d.req.act        = a;
      d.req.addr       = ad;
      d.req.port       = p;
      d.req.rebind_req = rb;
      d.req.target     = t;
      d.typed          = ty;
      d.rsp.status     = st;
      d.rsp.slot       = s;
      d.rsp.conn_id    = id;
      d.rsp.rebind     = rf;
      d.rsp.count      = c;
      return d;
   endfunction

   task automatic send_request(flow_request r, logic typed, flow_response typed_rsp);
      flow_response predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.act;
      req_tdata  <= {1'b0, r.target, r.rebind_req, r.port, r.addr};
      do @(posedge clock); while (!req_tready);
      predicted = table_outcome(r);
      awaited_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // limit changes only once every response is back
   task automatic write_limit(logic [LIMIT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tbl_limit = value;
   endtask

   initial begin : stimulus
      directed_row         dir_table [25];
      logic [LIMIT_W-1:0]  phase_limits [PHASES];
      logic [ADDR_W-1:0]   pool_addr [POOL_KEYS];
      logic [PORT_W-1:0]   pool_port [POOL_KEYS];
      flow_request         r;
      int                  pick;
      int                  k;
      int                  s;

      dir_table = '{
         row(0, 0, ACT_LOOKUP,    32'h0000_0000, 16'h0000, 0, 6'h00, 1, ST_CREATED, 0, 1, 0, 1),
         row(0, 0, ACT_LOOKUP,    32'hFFFF_FFFF, 16'hFFFF, 1, 6'h3F, 1, ST_CREATED, 1, 2, 1, 2),
         row(0, 0, ACT_LOOKUP,    32'h0000_0000, 16'h0000, 1, 6'h00, 1, ST_FOUND,   0, 1, 1, 2),
         row(0, 0, ACT_LOOKUP,    32'hFFFF_FFFF, 16'hFFFF, 0, 6'h00, 1, ST_FOUND,   1, 2, 1, 2),
         row(0, 0, ACT_MARK_SENT, 32'h1234_5678, 16'hABCD, 1, 6'h00, 1, ST_DONE,    0, 0, 0, 2),
         row(0, 0, ACT_LOOKUP,    32'h0000_0000, 16'h0000, 0, 6'h00, 1, ST_FOUND,   0, 1, 0, 2),
         row(0, 0, ACT_MARK_SENT, 32'h0000_0000, 16'h0000, 0, 6'h3F, 1, ST_DONE,   63, 0, 0, 2),
         row(0, 0, ACT_MARK_SENT, 32'h0000_0000, 16'h0000, 0, 6'h01, 1, ST_DONE,    1, 0, 0, 2),
         row(0, 0, ACT_LOOKUP,    32'hFFFF_FFFF, 16'hFFFF, 0, 6'h00, 1, ST_FOUND,   1, 2, 0, 2),
         row(0, 0, ACT_UNUSED,    32'hFFFF_FFFF, 16'hFFFF, 1, 6'h3F, 1, ST_DONE,    0, 0, 0, 2),
         // same address, other port: a new entry
         row(0, 0, ACT_LOOKUP,    32'h0000_0000, 16'h0001, 0, 6'h00, 1, ST_CREATED, 2, 3, 0, 3),
         row(0, 0, ACT_LOOKUP,    32'h0000_0001, 16'h0000, 1, 6'h00, 1, ST_CREATED, 3, 4, 1, 4),
         row(0, 0, ACT_LOOKUP,    32'h8000_0000, 16'h8000, 0, 6'h2A, 0, ST_DONE,    0, 0, 0, 0),
         row(0, 0, ACT_MARK_SENT, 32'h0000_0000, 16'h0000, 0, 6'h02, 1, ST_DONE,    2, 0, 0, 5),
         row(0, 0, ACT_LOOKUP,    32'h0000_0001, 16'h0000, 0, 6'h00, 1, ST_FOUND,   3, 4, 1, 5),
         row(0, 0, ACT_CLEAR,     32'hA5A5_A5A5, 16'h5A5A, 1, 6'h15, 1, ST_DONE,    0, 0, 0, 0),
         // ids restart after a clear
         row(0, 0, ACT_LOOKUP,    32'h0000_0001, 16'h0000, 0, 6'h00, 1, ST_CREATED, 0, 1, 0, 1),
         row(0, 0, ACT_LOOKUP,    32'hFFFF_FFFF, 16'hFFFF, 1, 6'h00, 1, ST_CREATED, 1, 2, 1, 2),
         row(0, 0, ACT_MARK_SENT, 32'hFFFF_FFFF, 16'hFFFF, 1, 6'h00, 1, ST_DONE,    0, 0, 0, 2),
         row(0, 0, ACT_LOOKUP,    32'h0000_FFFF, 16'hFFFF, 0, 6'h3F, 0, ST_DONE,    0, 0, 0, 0),
         row(0, 0, ACT_CLEAR,     32'hFFFF_FFFF, 16'hFFFF, 1, 6'h3F, 1, ST_DONE,    0, 0, 0, 0),
         row(0, 0, ACT_UNUSED,    32'h0000_0000, 16'h0000, 0, 6'h00, 1, ST_DONE,    0, 0, 0, 0),
         // limit of one: second key is refused, the first still found
         row(1, 1, ACT_LOOKUP,    32'h0000_0000, 16'h0000, 0, 6'h00, 1, ST_CREATED, 0, 1, 0, 1),
         row(0, 0, ACT_LOOKUP,    32'hFFFF_FFFF, 16'hFFFF, 1, 6'h00, 1, ST_FULL,    0, 0, 0, 1),
         row(0, 0, ACT_LOOKUP,    32'h0000_0000, 16'h0000, 1, 6'h00, 1, ST_FOUND,   0, 1, 1, 1)
      };
      phase_limits = '{7'd0, 7'd65, 7'd1, 7'd16, 7'd2, 7'd64, 7'd64};

      empty_table();
      tbl_limit = LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[n]) begin
         if (dir_table[n].set_limit)
            write_limit(dir_table[n].limit_val);
         send_request(dir_table[n].req, dir_table[n].typed, dir_table[n].rsp);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1)
            idle_on = 1'b0;
         write_limit(ph == 4 ? LIMIT_W'($urandom_range(2, 63)) : phase_limits[ph]);
         // some keys share an address and differ only in port
         for (int j = 0; j < POOL_KEYS; j++) begin
            pool_addr[j] = (j % 4 == 1) ? pool_addr[j - 1] : $urandom;
            pool_port[j] = $urandom_range(0, 65535);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            r.act        = ACT_LOOKUP;
            r.addr       = $urandom;
            r.port       = $urandom_range(0, 65535);
            r.rebind_req = $urandom_range(0, 1);
            r.target     = $urandom_range(0, SLOTS - 1);
            if (n < 70 && pick < 75) begin
               // fresh keys early in the phase so the table fills up
            end else if (pick < 60) begin
               k = $urandom_range(0, POOL_KEYS - 1);
               r.addr = pool_addr[k];
               r.port = pool_port[k];
            end else if (pick < 72) begin
            end else if (pick < 88) begin
               r.act = ACT_MARK_SENT;
               if (tbl_count > 0 && pick < 84) begin
                  do s = $urandom_range(0, SLOTS - 1); while (!tbl_valid[s]);
                  r.target = s[SLOT_OUT_W-1:0];
               end
            end else if (pick < 91 && n >= 70) begin
               r.act = ACT_CLEAR;
            end else if (pick < 94) begin
               r.act = ACT_UNUSED;
            end else begin
               k = $urandom_range(0, POOL_KEYS - 1);
               r.addr = pool_addr[k];
               r.port = pool_port[k];
               r.rebind_req = 1'b1;
            end
            send_request(r, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("flow_table_lookup_or_insert: match");
      end else begin
         $display("flow_table_lookup_or_insert: mismatch");
      end
      $finish;
   end

   always @(posedge clock) begin : response_pacing
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!held_off && responses_seen >= 300) begin
         // long hold-off while requests keep coming, so the block backs up
         rsp_tready <= 1'b0;
         stall_left <= HOLD_CYCLES;
         held_off   <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : response_check
      flow_response got;
      flow_response want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = status_type'(rsp_tuser);
         got.slot    = rsp_tdata[5:0];
         got.conn_id = rsp_tdata[21:6];
         got.rebind  = rsp_tdata[22];
         got.count   = rsp_tdata[29:23];
         responses_seen++;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d slot %0d id %0d rebind %0d count %0d",
                        got.status, got.slot, got.conn_id, got.rebind, got.count);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.conn_id !== want.conn_id || got.rebind !== want.rebind ||
                got.count !== want.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response %0d: expected status %0d slot %0d id %0d rebind %0d ",
                            "count %0d, got status %0d slot %0d id %0d rebind %0d count %0d"},
                           responses_seen, want.status, want.slot, want.conn_id, want.rebind,
                           want.count, got.status, got.slot, got.conn_id, got.rebind,
                           got.count);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("flow_table_lookup_or_insert: mismatch");
         $finish;
      end
   end

endmodule
